### sv/two_class_priority_queue_defines.svh
// Assertion macros shared by the checker of the two-class priority queue
`ifndef TWO_CLASS_PRIORITY_QUEUE_DEFINES_SVH
`define TWO_CLASS_PRIORITY_QUEUE_DEFINES_SVH

// Check a consequence in the same cycle as its trigger
`define TPQ_ASSERT_SAME(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error("tpq check failed");

// Check a consequence in the cycle after its trigger
`define TPQ_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("tpq check failed");

`endif

### sv/tpq_pkg.sv
// Shared types, constants and helpers for the two-class priority queue
package tpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int AGE_W       = 8;
  localparam int TAG_W       = 32;
  localparam int COUNT_W     = 5;
  localparam int ENTRY_W     = AGE_W + TAG_W;

  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [AGE_W-1:0] THRESHOLD_RESET = 8'd60;

  // Register index, taken from byte address bit 2
  typedef enum logic [0:0] {
    REG_AGE_THRESHOLD = 1'b0
  } reg_index_t;

  typedef enum logic [0:0] {
    OP_ADD   = 1'b0,
    OP_SERVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ADDED  = 2'd0,
    ST_FULL   = 2'd1,
    ST_SERVED = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CLS_NORMAL    = 1'b0,
    CLS_PREFERRED = 1'b1
  } class_t;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    status_t             status;
    class_t              entry_class;
    logic [AGE_W-1:0]    served_age;
    logic [TAG_W-1:0]    served_tag;
    logic [COUNT_W-1:0]  normal_count;
    logic [COUNT_W-1:0]  preferred_count;
  } result_t;

  // Step a ring pointer, wrapping after the last slot
  function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

### sv/tpq_if.sv
// Valid/ready channel interfaces for request and response words
interface tpq_req_if;
  logic        valid;
  logic        ready;
  logic [0:0]  operation;
  logic [7:0]  entry_age;
  logic [31:0] entry_tag;

  modport source (output valid, output operation, output entry_age, output entry_tag,
                  input ready);
  modport sink   (input valid, input operation, input entry_age, input entry_tag,
                  output ready);
endinterface

interface tpq_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [0:0]  entry_class;
  logic [7:0]  served_age;
  logic [31:0] served_tag;
  logic [4:0]  normal_count;
  logic [4:0]  preferred_count;

  modport source (output valid, output status, output entry_class, output served_age,
                  output served_tag, output normal_count, output preferred_count,
                  input ready);
  modport sink   (input valid, input status, input entry_class, input served_age,
                  input served_tag, input normal_count, input preferred_count,
                  output ready);
endinterface

### sv/tpq_ram.sv
// Simple dual-port synchronous RAM with registered read data
module tpq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/tpq_apb_regs.sv
// APB configuration register holding the age threshold
module tpq_apb_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tpq_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tpq_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tpq_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [tpq_pkg::AGE_W-1:0]      threshold
);
  import tpq_pkg::*;

  logic       wr_en;
  reg_index_t reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready && (reg_sel == REG_AGE_THRESHOLD);

  // Update threshold on a completed write
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (wr_en) begin
      threshold <= pwdata[AGE_W-1:0];
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_AGE_THRESHOLD: prdata = APB_DATA_W'(threshold);
      default:           prdata = '0;
    endcase
  end

endmodule

### sv/tpq_ctrl.sv
// Queue controller: ring pointers, fill counts and the two entry memories
module tpq_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  tpq_req_if.sink                   req,
  input  logic [tpq_pkg::AGE_W-1:0] threshold,
  input  logic                      buf_free,
  output logic                      res_valid,
  output tpq_pkg::result_t          res
);
  import tpq_pkg::*;

  ctrl_state_t       state, state_next;
  logic [PTR_W-1:0]  n_head, n_head_next, n_tail, n_tail_next;
  logic [PTR_W-1:0]  p_head, p_head_next, p_tail, p_tail_next;
  logic [FILL_W-1:0] n_fill, n_fill_next, p_fill, p_fill_next;
  class_t            rd_class, rd_class_next;

  logic              accept;
  logic              is_pref;
  logic              n_we, p_we, n_re, p_re;
  logic [ENTRY_W-1:0] wdata, n_rdata, p_rdata, rd_entry;

  assign req.ready = (state == S_IDLE) && buf_free;
  assign accept    = req.valid && req.ready;
  assign is_pref   = req.entry_age > threshold;
  assign wdata     = {req.entry_age, req.entry_tag};

  tpq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ENTRY_W)) u_normal_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_tail),
    .wdata (wdata),
    .re    (n_re),
    .raddr (n_head),
    .rdata (n_rdata)
  );

  tpq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ENTRY_W)) u_preferred_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_tail),
    .wdata (wdata),
    .re    (p_re),
    .raddr (p_head),
    .rdata (p_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (op_t'(req.operation) == OP_SERVE) &&
            ((p_fill != '0) || (n_fill != '0))) begin
          state_next = S_READ;
        end
      end
      S_READ:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Pointer, fill and memory control
  always_comb begin
    n_head_next   = n_head;
    n_tail_next   = n_tail;
    p_head_next   = p_head;
    p_tail_next   = p_tail;
    n_fill_next   = n_fill;
    p_fill_next   = p_fill;
    rd_class_next = rd_class;
    n_we = 1'b0;
    p_we = 1'b0;
    n_re = 1'b0;
    p_re = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (op_t'(req.operation) == OP_ADD) begin
            if (is_pref && (p_fill != FILL_W'(QUEUE_DEPTH))) begin
              p_we        = 1'b1;
              p_tail_next = ptr_advance(p_tail);
              p_fill_next = p_fill + 1'b1;
            end else if (!is_pref && (n_fill != FILL_W'(QUEUE_DEPTH))) begin
              n_we        = 1'b1;
              n_tail_next = ptr_advance(n_tail);
              n_fill_next = n_fill + 1'b1;
            end
          end else if (p_fill != '0) begin
            p_re          = 1'b1;
            p_head_next   = ptr_advance(p_head);
            p_fill_next   = p_fill - 1'b1;
            rd_class_next = CLS_PREFERRED;
          end else if (n_fill != '0) begin
            n_re          = 1'b1;
            n_head_next   = ptr_advance(n_head);
            n_fill_next   = n_fill - 1'b1;
            rd_class_next = CLS_NORMAL;
          end
        end
      end
      default: ;
    endcase
  end

  assign rd_entry = (rd_class == CLS_PREFERRED) ? p_rdata : n_rdata;

  // Result word: adds and empty serves finish at once, serves after the read
  always_comb begin
    res_valid           = 1'b0;
    res.status          = ST_ADDED;
    res.entry_class     = CLS_NORMAL;
    res.served_age      = '0;
    res.served_tag      = '0;
    res.normal_count    = COUNT_W'(n_fill_next);
    res.preferred_count = COUNT_W'(p_fill_next);
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (op_t'(req.operation) == OP_ADD) begin
            res_valid       = 1'b1;
            res.entry_class = is_pref ? CLS_PREFERRED : CLS_NORMAL;
            res.status      = (n_we || p_we) ? ST_ADDED : ST_FULL;
          end else if ((p_fill == '0) && (n_fill == '0)) begin
            res_valid  = 1'b1;
            res.status = ST_EMPTY;
          end
        end
      end
      S_READ: begin
        res_valid       = 1'b1;
        res.status      = ST_SERVED;
        res.entry_class = rd_class;
        res.served_age  = rd_entry[ENTRY_W-1:TAG_W];
        res.served_tag  = rd_entry[TAG_W-1:0];
      end
      default: ;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      n_head   <= '0;
      n_tail   <= '0;
      n_fill   <= '0;
      p_head   <= '0;
      p_tail   <= '0;
      p_fill   <= '0;
      rd_class <= CLS_NORMAL;
    end else begin
      state    <= state_next;
      n_head   <= n_head_next;
      n_tail   <= n_tail_next;
      n_fill   <= n_fill_next;
      p_head   <= p_head_next;
      p_tail   <= p_tail_next;
      p_fill   <= p_fill_next;
      rd_class <= rd_class_next;
    end
  end

endmodule

### sv/tpq_out_buf.sv
// Output register with one skid slot for result words
module tpq_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  input  tpq_pkg::result_t res,
  output logic             buf_free,
  tpq_rsp_if.source        rsp
);
  import tpq_pkg::*;

  logic    out_valid, skid_valid;
  result_t out_word, skid_word;
  logic    move;

  assign move     = !out_valid || rsp.ready;
  assign buf_free = !skid_valid;

  // Advance the skid slot into the output, or park a new word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (move) begin
      out_valid  <= skid_valid || res_valid;
      skid_valid <= 1'b0;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (res_valid) begin
        out_word <= res;
      end
    end else if (res_valid) begin
      skid_word <= res;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_word.status;
  assign rsp.entry_class     = out_word.entry_class;
  assign rsp.served_age      = out_word.served_age;
  assign rsp.served_tag      = out_word.served_tag;
  assign rsp.normal_count    = out_word.normal_count;
  assign rsp.preferred_count = out_word.preferred_count;

endmodule

### sv/two_class_priority_queue.sv
// Two-class priority queue: an add's result is registered at the output from acceptance,
// a serve's after the entry memory read. Adds and empty serves finish in the idle state;
// a serve of an entry also passes the read state, set by the registered entry memories.
// One result word may wait at the output while the next item is taken.
// Reset clears pointers and fill counts and sets the threshold to 60; the entry
// memories are not cleared and need no clearing pass.
module two_class_priority_queue (
  input  logic                           clk,
  input  logic                           rst,
  tpq_req_if.sink                        req,
  tpq_rsp_if.source                      rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tpq_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tpq_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tpq_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import tpq_pkg::*;

  logic [AGE_W-1:0] threshold;
  logic             buf_free;
  logic             res_valid;
  result_t          res;

  tpq_apb_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .threshold (threshold)
  );

  tpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .threshold (threshold),
    .buf_free  (buf_free),
    .res_valid (res_valid),
    .res       (res)
  );

  tpq_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .buf_free  (buf_free),
    .rsp       (rsp)
  );

endmodule

### sv/tpq_checker.sv
// Port-level checks for the two-class priority queue, bound to the top level
`include "two_class_priority_queue_defines.svh"

module tpq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [1:0]                  rsp_status,
  input logic [0:0]                  rsp_entry_class,
  input logic [tpq_pkg::AGE_W-1:0]   rsp_served_age,
  input logic [tpq_pkg::TAG_W-1:0]   rsp_served_tag,
  input logic [tpq_pkg::COUNT_W-1:0] rsp_normal_count,
  input logic [tpq_pkg::COUNT_W-1:0] rsp_preferred_count
);
  import tpq_pkg::*;

  logic    out_take;
  logic    is_served, is_empty, is_full, is_add;

  assign out_take  = rsp_valid && rsp_ready;
  assign is_served = rsp_status == ST_SERVED;
  assign is_empty  = rsp_status == ST_EMPTY;
  assign is_full   = rsp_status == ST_FULL;
  assign is_add    = rsp_status == ST_ADDED;

  // A normal entry is served only when nothing preferential remains
  `TPQ_ASSERT_SAME(a_strict_priority, out_take && is_served && (rsp_entry_class == CLS_NORMAL), rsp_preferred_count == '0)
  // Nothing to serve means both queues are empty
  `TPQ_ASSERT_SAME(a_empty_serve, out_take && is_empty, (rsp_normal_count == '0) && (rsp_preferred_count == '0) && (rsp_entry_class == CLS_NORMAL))
  // A rejected add names a queue that is full
  `TPQ_ASSERT_SAME(a_full_reject, out_take && is_full, (rsp_entry_class == CLS_PREFERRED) ? (rsp_preferred_count == COUNT_W'(QUEUE_DEPTH)) : (rsp_normal_count == COUNT_W'(QUEUE_DEPTH)))
  // Add, full and empty-serve results carry no served word
  `TPQ_ASSERT_SAME(a_add_no_data, out_take && (is_add || is_full || is_empty), (rsp_served_age == '0) && (rsp_served_tag == '0))
  // A pending word stays offered
  `TPQ_ASSERT_NEXT(a_valid_hold, rsp_valid && !rsp_ready, rsp_valid)

endmodule

bind two_class_priority_queue tpq_checker u_tpq_checker (
  .clk                 (clk),
  .rst                 (rst),
  .rsp_valid           (rsp.valid),
  .rsp_ready           (rsp.ready),
  .rsp_status          (rsp.status),
  .rsp_entry_class     (rsp.entry_class),
  .rsp_served_age      (rsp.served_age),
  .rsp_served_tag      (rsp.served_tag),
  .rsp_normal_count    (rsp.normal_count),
  .rsp_preferred_count (rsp.preferred_count)
);

### tb/sv/two_class_priority_queue_tb.sv
// Self-checking testbench for the two-class priority queue
module two_class_priority_queue_tb;
  import tpq_pkg::*;

  localparam logic [APB_ADDR_W-1:0] THRESHOLD_ADDR = {REG_AGE_THRESHOLD, 2'b00};
  // one register slot past the last one; writes there must have no effect
  localparam logic [APB_ADDR_W-1:0] SPARE_ADDR     = 3'd4;
  localparam int RANDOM_WORDS  = 830;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 10;
  localparam int GAP_PCT       = 35;
  localparam int RUN_LIMIT     = 4_000_000;

  typedef struct packed {
    logic [AGE_W-1:0] age;
    logic [TAG_W-1:0] tag;
  } slot_t;

  // Mirror of both rings plus the threshold; predicts one response per request
  class tpq_ledger;
    logic [AGE_W-1:0] threshold;
    slot_t            normal_ring[$];
    slot_t            preferred_ring[$];
    result_t          owed[$];
    int               errors;
    int               checked;
    int               hits[4];

    function new();
      threshold = THRESHOLD_RESET;
      errors    = 0;
      checked   = 0;
      foreach (hits[i]) hits[i] = 0;
    endfunction

    function void fault(string what);
      if (errors < 10) $display("MISMATCH: %s", what);
      errors++;
    endfunction

    // Predict the response word for one accepted request word
    function void take_request(op_t op, logic [AGE_W-1:0] age, logic [TAG_W-1:0] tag);
      result_t want;
      slot_t   s;
      want = '0;
      if (op == OP_ADD) begin
        if (age > threshold) begin
          want.entry_class = CLS_PREFERRED;
          if (preferred_ring.size() >= QUEUE_DEPTH) begin
            want.status = ST_FULL;
          end else begin
            preferred_ring.push_back('{age: age, tag: tag});
            want.status = ST_ADDED;
          end
        end else begin
          want.entry_class = CLS_NORMAL;
          if (normal_ring.size() >= QUEUE_DEPTH) begin
            want.status = ST_FULL;
          end else begin
            normal_ring.push_back('{age: age, tag: tag});
            want.status = ST_ADDED;
          end
        end
      end else if (preferred_ring.size() > 0) begin
        s = preferred_ring.pop_front();
        want.status      = ST_SERVED;
        want.entry_class = CLS_PREFERRED;
        want.served_age  = s.age;
        want.served_tag  = s.tag;
      end else if (normal_ring.size() > 0) begin
        s = normal_ring.pop_front();
        want.status      = ST_SERVED;
        want.entry_class = CLS_NORMAL;
        want.served_age  = s.age;
        want.served_tag  = s.tag;
      end else begin
        want.status = ST_EMPTY;
      end
      want.normal_count    = COUNT_W'(normal_ring.size());
      want.preferred_count = COUNT_W'(preferred_ring.size());
      owed.push_back(want);
    endfunction

    // Compare one response word with the oldest prediction
    function void match_response(result_t got);
      result_t want;
      if (owed.size() == 0) begin
        fault($sformatf("response with nothing outstanding: st=%0d cls=%0d age=%0d tag=%h",
                        got.status, got.entry_class, got.served_age, got.served_tag));
        return;
      end
      want = owed.pop_front();
      checked++;
      hits[int'(want.status)]++;
      if (got.status !== want.status || got.entry_class !== want.entry_class ||
          got.served_age !== want.served_age || got.served_tag !== want.served_tag ||
          got.normal_count !== want.normal_count ||
          got.preferred_count !== want.preferred_count)
        fault($sformatf({"response %0d: expected st=%0d cls=%0d age=%0d tag=%h n=%0d p=%0d,",
                         " got st=%0d cls=%0d age=%0d tag=%h n=%0d p=%0d"},
                        checked, want.status, want.entry_class, want.served_age,
                        want.served_tag, want.normal_count, want.preferred_count,
                        got.status, got.entry_class, got.served_age, got.served_tag,
                        got.normal_count, got.preferred_count));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  tpq_req_if req_ch ();
  tpq_rsp_if rsp_ch ();

  tpq_ledger ledger;
  bit        in_gaps;
  bit        out_stalls;
  int        words_sent;
  int        settings_used;

  two_class_priority_queue dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Generate the clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drive response ready, stalling at random when enabled
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (out_stalls) begin
      rsp_ch.ready <= ($urandom_range(99) >= GAP_PCT);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Record accepted request words and check accepted response words
  always @(posedge clk) begin
    result_t got;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        ledger.take_request(op_t'(req_ch.operation), req_ch.entry_age, req_ch.entry_tag);
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status          = status_t'(rsp_ch.status);
        got.entry_class     = class_t'(rsp_ch.entry_class);
        got.served_age      = rsp_ch.served_age;
        got.served_tag      = rsp_ch.served_tag;
        got.normal_count    = rsp_ch.normal_count;
        got.preferred_count = rsp_ch.preferred_count;
        ledger.match_response(got);
      end
    end
  end

  // Present one request word and hold it until accepted
  task automatic send_word(input op_t op, input logic [AGE_W-1:0] age,
                           input logic [TAG_W-1:0] tag);
    while (in_gaps && $urandom_range(99) < GAP_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.entry_age <= age;
    req_ch.entry_tag <= tag;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // Drop valid and wait until every predicted response has arrived
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (ledger.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == THRESHOLD_ADDR) ledger.threshold = data[AGE_W-1:0];
  endtask

  task automatic read_reg(input logic [APB_ADDR_W-1:0] addr,
                          output logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write the threshold and confirm it reads back
  task automatic set_threshold(input logic [AGE_W-1:0] value);
    logic [APB_DATA_W-1:0] rd;
    write_reg(THRESHOLD_ADDR, {$urandom} & ~32'hFF | value);
    read_reg(THRESHOLD_ADDR, rd);
    if (rd[AGE_W-1:0] !== ledger.threshold)
      ledger.fault($sformatf("threshold readback: expected %0d, got %0d",
                             ledger.threshold, rd[AGE_W-1:0]));
    settings_used++;
  endtask

  // Stop a hung run
  initial begin
    #(RUN_LIMIT);
    $display("Timeout: %0d responses still outstanding", ledger.owed.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [APB_DATA_W-1:0] rd;
    int                    seg;
    int                    seg_len;
    int                    add_pct;
    int                    near;
    op_t                   op;
    logic [AGE_W-1:0]      age;

    ledger           = new();
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.operation = OP_ADD;
    req_ch.entry_age = '0;
    req_ch.entry_tag = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_gaps          = 1'b0;
    out_stalls       = 1'b0;
    words_sent       = 0;
    settings_used    = 0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Threshold comes out of reset at its default
    read_reg(THRESHOLD_ADDR, rd);
    if (rd[AGE_W-1:0] !== THRESHOLD_RESET)
      ledger.fault($sformatf("threshold after reset: expected %0d, got %0d",
                             THRESHOLD_RESET, rd[AGE_W-1:0]));

    // Serve from empty, adds at the field extremes and on both sides of the threshold
    send_word(OP_SERVE, 8'd0, 32'h0);
    send_word(OP_ADD, 8'd0, 32'h0000_0000);
    send_word(OP_ADD, 8'd60, 32'hFFFF_FFFF);
    send_word(OP_ADD, 8'd61, 32'hA5A5_A5A5);
    send_word(OP_ADD, 8'd255, 32'h5A5A_5A5A);
    repeat (5) send_word(OP_SERVE, 8'hFF, 32'hFFFF_FFFF);
    settle();

    // A write past the last register must leave the threshold alone
    write_reg(SPARE_ADDR, 32'h0000_0005);
    set_threshold(8'd0);
    send_word(OP_ADD, 8'd0, 32'h1234_5678);
    send_word(OP_ADD, 8'd1, 32'h8765_4321);
    send_word(OP_SERVE, 8'd0, 32'h0);
    send_word(OP_SERVE, 8'd0, 32'h0);
    settle();
    set_threshold(8'd255);
    send_word(OP_ADD, 8'd255, 32'hDEAD_BEEF);
    send_word(OP_ADD, 8'd128, 32'h0F0F_0F0F);
    send_word(OP_SERVE, 8'd0, 32'h0);
    send_word(OP_SERVE, 8'd0, 32'h0);
    settle();

    // Random segments: fill-heavy, drain-heavy or balanced, each under a new threshold
    for (seg = 0; words_sent < RANDOM_WORDS + 20; seg++) begin
      case (seg % 5)
        0:       set_threshold(8'd0);
        1:       set_threshold(8'd255);
        2:       set_threshold(THRESHOLD_RESET);
        default: set_threshold(8'($urandom));
      endcase
      if (seg % 7 == 3) write_reg(SPARE_ADDR, $urandom);
      in_gaps    = (seg % 6 != 2);
      out_stalls = (seg % 6 != 2) && (seg % 6 != 4);
      case ($urandom_range(2))
        0:       add_pct = 90;
        1:       add_pct = 25;
        default: add_pct = 55;
      endcase
      seg_len = $urandom_range(20, 60);
      repeat (seg_len) begin
        op = ($urandom_range(99) < add_pct) ? OP_ADD : OP_SERVE;
        case ($urandom_range(3))
          0, 1: age = 8'($urandom);
          2: begin
            near = int'(ledger.threshold) + $urandom_range(4) - 2;
            age  = (near < 0) ? 8'd0 : (near > 255) ? 8'd255 : 8'(near);
          end
          default: age = $urandom_range(1) ? 8'd255 : 8'd0;
        endcase
        send_word(op, age, $urandom);
      end
      settle();
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d request words over %0d threshold settings; checked %0d responses",
             words_sent, settings_used, ledger.checked);
    $display("Outcomes: %0d added, %0d rejected full, %0d served, %0d empty serves",
             ledger.hits[ST_ADDED], ledger.hits[ST_FULL], ledger.hits[ST_SERVED],
             ledger.hits[ST_EMPTY]);
    if (ledger.errors == 0 && ledger.owed.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d responses missing", ledger.errors, ledger.owed.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
